FILE: src/vosl_pkg.sv
// vosl_pkg: shared types and constants for the view offset slew limiter
// no dependencies; used by vosl_cfg_regs, vosl_core and the top level
`default_nettype none

package vosl_pkg;

    localparam int ANG_W = 18;

    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang FULL_TURN  = 18'sd23040;
    localparam t_ang HALF_TURN  = 18'sd11520;
    localparam t_ang TILT_LIMIT = 18'sd5760;

    typedef enum logic [2:0] {
        REQ_TICK         = 3'd0,
        REQ_GOAL_HEADING = 3'd1,
        REQ_GOAL_PITCH   = 3'd2,
        REQ_GOAL_ROLL    = 3'd3,
        REQ_CUR_HEADING  = 3'd4,
        REQ_CUR_PITCH    = 3'd5,
        REQ_CUR_ROLL     = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        CFG_HEADING_STEP = 2'd0,
        CFG_TILT_STEP    = 2'd1,
        CFG_SNAP_WINDOW  = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] HEADING_STEP_RST = 8'd32;
    localparam logic [7:0] TILT_STEP_RST    = 8'd64;
    localparam logic [7:0] SNAP_WINDOW_RST  = 8'd64;

    typedef struct packed {
        logic [7:0] heading_step;
        logic [7:0] tilt_step;
        logic [7:0] snap_window;
    } t_cfg;

    typedef struct packed {
        logic              all_settled;
        logic signed [13:0] roll_now;
        logic signed [13:0] pitch_now;
        logic [14:0]        heading_now;
    } t_result;

endpackage

`default_nettype wire

FILE: src/view_offset_slew_limiter_top.sv
// view_offset_slew_limiter_top: stream wrapper with input and result registers
// depends on vosl_pkg, vosl_cfg_regs and vosl_core
//
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata angle, tuser request kind
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata heading, pitch, roll, settled
// cfg      | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one transaction per cycle while the result register is not stalled
// the whole tick update sits between the input register and the result register
// synchronous active-low reset returns steps, window and all angles to defaults
// a stalled result holds; the input register still takes one more transaction
`default_nettype none

module view_offset_slew_limiter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] angle_value
    input  wire logic [2:0]  s_axis_tuser,  // [2:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // [14:0] heading_now, [28:15] pitch_now,
                                            // [42:29] roll_now, [43] all_settled, zero pad
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic               r_s1_valid;
    logic [2:0]         r_s1_req;
    logic signed [15:0] r_s1_angle;
    logic               r_out_valid;
    logic [47:0]        r_out_data;
    logic               w_advance;
    logic               w_fire;
    vosl_pkg::t_cfg     w_cfg;
    vosl_pkg::t_result  w_result;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_s1_valid && w_advance;
    assign s_axis_tready = !r_s1_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    vosl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    vosl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_req    (r_s1_req),
        .i_angle  (r_s1_angle),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_s1_valid <= s_axis_tvalid;
            if (w_advance) r_out_valid <= r_s1_valid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_req   <= s_axis_tuser;
            r_s1_angle <= s_axis_tdata;
        end
        if (w_fire) begin
            r_out_data <= {4'd0, w_result};
        end
    end

    a_fire_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed transaction produced no result");

    a_s1_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_advance |=> r_s1_valid && $stable(r_s1_req) && $stable(r_s1_angle))
        else $error("pending transaction lost during stall");

    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: src/vosl_cfg_regs.sv
// vosl_cfg_regs: step and snap window registers behind the config write channel
// depends on vosl_pkg
`default_nettype none

module vosl_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_index,
    input  wire logic [7:0]     i_data,
    output vosl_pkg::t_cfg      o_cfg
);

    vosl_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heading_step <= vosl_pkg::HEADING_STEP_RST;
            r_cfg.tilt_step    <= vosl_pkg::TILT_STEP_RST;
            r_cfg.snap_window  <= vosl_pkg::SNAP_WINDOW_RST;
        end else if (i_valid) begin
            unique case (i_index)
                vosl_pkg::CFG_HEADING_STEP: r_cfg.heading_step <= i_data;
                vosl_pkg::CFG_TILT_STEP:    r_cfg.tilt_step    <= i_data;
                vosl_pkg::CFG_SNAP_WINDOW:  r_cfg.snap_window  <= i_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/vosl_core.sv
// vosl_core: angle state registers and the single-pass tick and set logic
// depends on vosl_pkg; result reflects the state after the transaction
`default_nettype none

module vosl_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic [2:0]         i_req,
    input  wire logic signed [15:0] i_angle,
    input  vosl_pkg::t_cfg          i_cfg,
    output vosl_pkg::t_result       o_result
);

    logic [14:0]        r_cur_heading, n_cur_heading;
    logic signed [13:0] r_cur_pitch,   n_cur_pitch;
    logic signed [13:0] r_cur_roll,    n_cur_roll;
    logic [14:0]        r_goal_heading, n_goal_heading;
    logic signed [13:0] r_goal_pitch,  n_goal_pitch;
    logic signed [15:0] r_goal_roll,   n_goal_roll;

    vosl_pkg::t_ang w_ang, w_hd_next, w_pitch_next, w_roll_next;
    vosl_pkg::t_ang w_wrapped, w_hd_set, w_tilt_set;

    function automatic vosl_pkg::t_ang ext8(input logic [7:0] v);
        return vosl_pkg::t_ang'({10'd0, v});
    endfunction

    function automatic vosl_pkg::t_ang clamp_ang(input vosl_pkg::t_ang v,
                                                 input vosl_pkg::t_ang lo,
                                                 input vosl_pkg::t_ang hi);
        vosl_pkg::t_ang res;
        if (v < lo) res = lo;
        else if (v > hi) res = hi;
        else res = v;
        return res;
    endfunction

    function automatic vosl_pkg::t_ang tilt_next(input vosl_pkg::t_ang cur,
                                                 input vosl_pkg::t_ang goal,
                                                 input logic [7:0] step,
                                                 input logic [7:0] window);
        vosl_pkg::t_ang diff;
        vosl_pkg::t_ang mag;
        vosl_pkg::t_ang res;
        diff = goal - cur;
        mag  = (diff < 0) ? -diff : diff;
        if (mag < ext8(window)) begin
            res = goal;
        end else begin
            res = (diff > 0) ? cur + ext8(step) : cur - ext8(step);
            res = clamp_ang(res, -vosl_pkg::TILT_LIMIT, vosl_pkg::TILT_LIMIT);
        end
        return res;
    endfunction

    function automatic vosl_pkg::t_ang heading_next(input vosl_pkg::t_ang cur,
                                                    input vosl_pkg::t_ang goal,
                                                    input logic [7:0] step,
                                                    input logic [7:0] window);
        vosl_pkg::t_ang diff;
        vosl_pkg::t_ang mag;
        vosl_pkg::t_ang res;
        logic           up;
        diff = goal - cur;
        mag  = (diff < 0) ? -diff : diff;
        up   = (diff > 0) ? (diff < vosl_pkg::HALF_TURN) : (mag >= vosl_pkg::HALF_TURN);
        if (mag < ext8(window)) begin
            res = goal;
        end else begin
            res = up ? cur + ext8(step) : cur - ext8(step);
            if (res > vosl_pkg::FULL_TURN) res = res - vosl_pkg::FULL_TURN;
            else if (res < 0) res = res + vosl_pkg::FULL_TURN;
        end
        return res;
    endfunction

    assign w_ang = vosl_pkg::t_ang'(i_angle);

    // goal heading wrap: the input span needs at most two turns of correction
    always_comb begin
        if (w_ang < -vosl_pkg::FULL_TURN) w_wrapped = w_ang + vosl_pkg::FULL_TURN
                                                    + vosl_pkg::FULL_TURN;
        else if (w_ang < 0) w_wrapped = w_ang + vosl_pkg::FULL_TURN;
        else if (w_ang > vosl_pkg::FULL_TURN) w_wrapped = w_ang - vosl_pkg::FULL_TURN;
        else w_wrapped = w_ang;
    end

    assign w_hd_set   = clamp_ang(w_ang, '0, vosl_pkg::FULL_TURN);
    assign w_tilt_set = clamp_ang(w_ang, -vosl_pkg::TILT_LIMIT, vosl_pkg::TILT_LIMIT);

    assign w_hd_next = heading_next(vosl_pkg::t_ang'({3'd0, r_cur_heading}),
                                    vosl_pkg::t_ang'({3'd0, r_goal_heading}),
                                    i_cfg.heading_step, i_cfg.snap_window);
    assign w_pitch_next = tilt_next(vosl_pkg::t_ang'(r_cur_pitch),
                                    vosl_pkg::t_ang'(r_goal_pitch),
                                    i_cfg.tilt_step, i_cfg.snap_window);
    assign w_roll_next  = tilt_next(vosl_pkg::t_ang'(r_cur_roll),
                                    vosl_pkg::t_ang'(r_goal_roll),
                                    i_cfg.tilt_step, i_cfg.snap_window);

    always_comb begin
        n_cur_heading  = r_cur_heading;
        n_cur_pitch    = r_cur_pitch;
        n_cur_roll     = r_cur_roll;
        n_goal_heading = r_goal_heading;
        n_goal_pitch   = r_goal_pitch;
        n_goal_roll    = r_goal_roll;
        if (i_fire) begin
            unique case (i_req)
                vosl_pkg::REQ_TICK: begin
                    n_cur_heading = w_hd_next[14:0];
                    n_cur_pitch   = w_pitch_next[13:0];
                    n_cur_roll    = w_roll_next[13:0];
                end
                vosl_pkg::REQ_GOAL_HEADING: n_goal_heading = w_wrapped[14:0];
                vosl_pkg::REQ_GOAL_PITCH:   n_goal_pitch   = w_tilt_set[13:0];
                vosl_pkg::REQ_GOAL_ROLL:    n_goal_roll    = i_angle;
                vosl_pkg::REQ_CUR_HEADING:  n_cur_heading  = w_hd_set[14:0];
                vosl_pkg::REQ_CUR_PITCH:    n_cur_pitch    = w_tilt_set[13:0];
                vosl_pkg::REQ_CUR_ROLL:     n_cur_roll     = w_tilt_set[13:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_heading  <= '0;
            r_cur_pitch    <= '0;
            r_cur_roll     <= '0;
            r_goal_heading <= '0;
            r_goal_pitch   <= '0;
            r_goal_roll    <= '0;
        end else begin
            r_cur_heading  <= n_cur_heading;
            r_cur_pitch    <= n_cur_pitch;
            r_cur_roll     <= n_cur_roll;
            r_goal_heading <= n_goal_heading;
            r_goal_pitch   <= n_goal_pitch;
            r_goal_roll    <= n_goal_roll;
        end
    end

    assign o_result.heading_now = n_cur_heading;
    assign o_result.pitch_now   = n_cur_pitch;
    assign o_result.roll_now    = n_cur_roll;
    assign o_result.all_settled = (n_cur_heading == n_goal_heading)
                                && (n_cur_pitch == n_goal_pitch)
                                && ({{2{n_cur_roll[13]}}, n_cur_roll} == n_goal_roll);

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_heading <= 15'd23040 && r_goal_heading <= 15'd23040)
        else $error("heading left 0..360 degrees");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_pitch >= -14'sd5760 && r_cur_pitch <= 14'sd5760)
        else $error("pitch left +/-90 degrees");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_cur_heading) && $stable(r_cur_pitch) && $stable(r_cur_roll))
        else $error("angle state moved without a transaction");

endmodule

`default_nettype wire
